[design/pkcsck_pkg.sv]
// Package for the PKCS#1 v1.5 signature encoding checker.
// Holds beat and control types, register and status codes, and the DigestInfo prefix table.
// No dependencies.
package pkcsck_pkg;

    localparam int MAX_BLOCK_BYTES          = 512;
    localparam int DEFAULT_MAX_DIGEST_BYTES = 48;
    localparam int LEN_W                    = 11;
    localparam int POS_W                    = 10;
    localparam int CFG_W                    = 10;

    localparam logic [LEN_W-1:0] MAX_BLOCK_LEN  = LEN_W'(MAX_BLOCK_BYTES);
    localparam logic [LEN_W-1:0] PREFIX_LEN     = 11'd19;
    localparam logic [LEN_W-1:0] DLEN_SHA256    = 11'd32;
    localparam logic [LEN_W-1:0] DLEN_SHA384    = 11'd48;
    // 00 01, at least eight FF bytes, 00: eleven bytes of framing
    localparam logic [LEN_W-1:0] FRAME_OVERHEAD = 11'd11;

    localparam logic [CFG_W-1:0] BLOCK_BYTES_RESET = 10'd256;

    localparam logic KIND_DIGEST = 1'b0;
    localparam logic KIND_BLOCK  = 1'b1;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] BYTE_PAD  = 8'hFF;

    typedef enum logic [0:0] {
        REG_BLOCK_BYTES = 1'b0,
        REG_DIGEST_KIND = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_MISMATCH  = 2'd2
    } t_status;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic    matched;
        t_status status;
    } t_out_beat;

    // Control handed from the position/decode stage to the compare stage
    typedef struct packed {
        logic       cmp_en;
        logic       use_store;
        logic [7:0] exp_byte;
        logic [7:0] data_byte;
        logic       last;
        logic       too_short;
    } t_cmp_ctl;

    // DigestInfo prefix byte; the two hashes differ in three places only
    function automatic logic [7:0] prefix_byte(input logic sha384, input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h30;
            5'd1:    b = sha384 ? 8'h41 : 8'h31;
            5'd2:    b = 8'h30;
            5'd3:    b = 8'h0D;
            5'd4:    b = 8'h06;
            5'd5:    b = 8'h09;
            5'd6:    b = 8'h60;
            5'd7:    b = 8'h86;
            5'd8:    b = 8'h48;
            5'd9:    b = 8'h01;
            5'd10:   b = 8'h65;
            5'd11:   b = 8'h03;
            5'd12:   b = 8'h04;
            5'd13:   b = 8'h02;
            5'd14:   b = sha384 ? 8'h02 : 8'h01;
            5'd15:   b = 8'h05;
            5'd16:   b = 8'h00;
            5'd17:   b = 8'h04;
            5'd18:   b = sha384 ? 8'h30 : 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[design/pkcsck_dstore.sv]
// Digest store: one write port, one read port, registered read data.
// Depends on pkcsck_pkg.
module pkcsck_dstore import pkcsck_pkg::*; #(
    parameter int MAX_DIGEST_BYTES = DEFAULT_MAX_DIGEST_BYTES,
    localparam int AW = $clog2(MAX_DIGEST_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] mem [MAX_DIGEST_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next block byte that needs the store
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/pkcsck_front.sv]
// Front stage: config registers, digest load index, block position and expected-byte decode.
// Issues store writes and reads, registers compare control. Depends on pkcsck_pkg.
module pkcsck_front import pkcsck_pkg::*; #(
    parameter int MAX_DIGEST_BYTES = DEFAULT_MAX_DIGEST_BYTES,
    localparam int AW = $clog2(MAX_DIGEST_BYTES),
    localparam int LW = $clog2(MAX_DIGEST_BYTES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  t_in_beat         i_in_beat,
    input  logic             i_adv,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic [7:0]       o_wr_data,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_addr,
    output logic             o_s1_valid,
    output t_cmp_ctl         o_s1
);

    localparam logic [LW-1:0]    LOAD_MAX = LW'(MAX_DIGEST_BYTES);
    localparam logic [LEN_W-1:0] STORE_LEN = LEN_W'(MAX_DIGEST_BYTES);

    logic [CFG_W-1:0] r_block_bytes;
    logic             r_digest_kind;
    logic [LW-1:0]    r_load_idx, n_load_idx;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_s1_valid;
    t_cmp_ctl         r_s1, n_s1;

    logic             accept, blk_beat, dig_beat;
    logic [LEN_W-1:0] eff_len, dlen, dstart, pstart, sep, pos11, pidx, didx;

    assign accept   = i_in_valid && i_adv;
    assign blk_beat = accept && (i_in_beat.kind == KIND_BLOCK);
    assign dig_beat = accept && (i_in_beat.kind == KIND_DIGEST);

    always_comb begin
        if (r_block_bytes == '0) begin
            eff_len = 11'd1;
        end else if ({1'b0, r_block_bytes} > MAX_BLOCK_LEN) begin
            eff_len = MAX_BLOCK_LEN;
        end else begin
            eff_len = {1'b0, r_block_bytes};
        end
    end

    assign dlen   = r_digest_kind ? DLEN_SHA384 : DLEN_SHA256;
    assign dstart = eff_len - dlen;
    assign pstart = dstart - PREFIX_LEN;
    assign sep    = pstart - 11'd1;
    assign pos11  = {1'b0, r_pos};
    assign pidx   = pos11 - pstart;
    assign didx   = pos11 - dstart;

    always_comb begin
        n_s1           = '0;
        n_s1.data_byte = i_in_beat.data_byte;
        n_s1.too_short = eff_len < (PREFIX_LEN + dlen + FRAME_OVERHEAD);
        n_s1.last      = (pos11 + 11'd1) >= eff_len;
        n_s1.cmp_en    = !n_s1.too_short && (pos11 < eff_len);
        if (pos11 == 11'd0) begin
            n_s1.exp_byte = BYTE_ZERO;
        end else if (pos11 == 11'd1) begin
            n_s1.exp_byte = BYTE_ONE;
        end else if (pos11 < sep) begin
            n_s1.exp_byte = BYTE_PAD;
        end else if (pos11 == sep) begin
            n_s1.exp_byte = BYTE_ZERO;
        end else if (pos11 < dstart) begin
            n_s1.exp_byte = prefix_byte(r_digest_kind, pidx[4:0]);
        end else if (didx < STORE_LEN) begin
            n_s1.use_store = 1'b1;
        end else begin
            // digest positions past the store compare against zero
            n_s1.exp_byte = BYTE_ZERO;
        end
    end

    assign o_wr_en   = dig_beat && (r_load_idx < LOAD_MAX);
    assign o_wr_addr = r_load_idx[AW-1:0];
    assign o_wr_data = i_in_beat.data_byte;
    assign o_rd_en   = blk_beat && n_s1.use_store;
    assign o_rd_addr = didx[AW-1:0];

    always_comb begin
        n_load_idx = r_load_idx;
        n_pos      = r_pos;
        if (blk_beat && n_s1.last) begin
            n_load_idx = '0;
            n_pos      = '0;
        end else if (blk_beat) begin
            n_pos = r_pos + 10'd1;
        end else if (o_wr_en) begin
            n_load_idx = r_load_idx + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BLOCK_BYTES_RESET;
            r_digest_kind <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_BLOCK_BYTES: r_block_bytes <= i_cfg_wdata;
                REG_DIGEST_KIND: r_digest_kind <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_load_idx <= n_load_idx;
            r_pos      <= n_pos;
            if (i_adv) begin
                r_s1_valid <= blk_beat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

[design/pkcsck_verdict.sv]
// Compare stage: checks each block byte, keeps the sticky mismatch flag, drives the result register.
// Depends on pkcsck_pkg.
module pkcsck_verdict import pkcsck_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s1_valid,
    input  t_cmp_ctl   i_s1,
    input  logic [7:0] i_rd_data,
    input  logic       i_out_stall,
    output logic       o_hold,
    output logic       o_out_valid,
    output t_out_beat  o_out_beat
);

    logic       r_mis, n_mis;
    logic       r_out_valid;
    t_out_beat  r_out_beat, result;
    logic [7:0] exp_byte;
    logic       mis_now, mis_all, consume, fire;

    assign exp_byte = i_s1.use_store ? i_rd_data : i_s1.exp_byte;
    assign mis_now  = i_s1.cmp_en && (exp_byte != i_s1.data_byte);
    assign mis_all  = r_mis || mis_now;

    // hold the last byte only when the previous result is still waiting
    assign o_hold  = i_s1_valid && i_s1.last && r_out_valid && i_out_stall;
    assign consume = i_s1_valid && !o_hold;
    assign fire    = consume && i_s1.last;

    always_comb begin
        if (i_s1.too_short) begin
            result = '{matched: 1'b0, status: ST_TOO_SHORT};
        end else if (mis_all) begin
            result = '{matched: 1'b0, status: ST_MISMATCH};
        end else begin
            result = '{matched: 1'b1, status: ST_OK};
        end
    end

    always_comb begin
        n_mis = r_mis;
        if (consume) begin
            n_mis = i_s1.last ? 1'b0 : mis_all;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mis       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mis <= n_mis;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_beat <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    a_fire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("result register not loaded after last byte");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !fire) |=> !r_out_valid)
        else $error("taken result shown again");

    a_flag_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> !r_mis)
        else $error("mismatch flag leaks into the next block");

    a_match_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_beat.matched) |-> (r_out_beat.status == ST_OK))
        else $error("match reported with a failing status");

endmodule

[design/pkcs1_v15_padding_checker_top.sv]
// PKCS#1 v1.5 signature encoding checker, top level.
// Depends on pkcsck_pkg, pkcsck_front, pkcsck_dstore and pkcsck_verdict.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_beat): a beat of kind 0 loads
//    the next digest byte into the store; a beat of kind 1 is the next byte of
//    the recovered block, most significant first. Digest bytes go first.
//  - Output channel (o_out_valid / i_out_stall / o_out_beat): one beat per block,
//    after its last byte: matched, and status ok, too short or mismatch.
//  - Config port: block_bytes (index 0) and digest_kind (index 1); write only
//    while no block is in flight.
//  - Throughput: one beat per cycle, digest or block byte, while o_in_stall is
//    low. The block position counter and a registered digest store read feed
//    a single byte compare. Result path: the last byte is registered as
//    compare control, then o_out_valid rises from the result register.
//  - Stall: a waiting result sits in the output register; input keeps flowing
//    until the next last byte reaches the compare stage, which then holds and
//    raises o_in_stall until the waiting beat is taken.
//  - Reset: block_bytes 256, SHA-256, position, load index and mismatch flag
//    cleared. The digest store keeps whatever it holds; no clearing pass, so
//    the block is ready as soon as reset is released.
module pkcs1_v15_padding_checker_top import pkcsck_pkg::*; #(
    parameter int MAX_DIGEST_BYTES = DEFAULT_MAX_DIGEST_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_beat         i_in_beat,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_beat        o_out_beat
);

    localparam int AW = $clog2(MAX_DIGEST_BYTES);

    logic          hold;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;
    logic          s1_valid;
    t_cmp_ctl      s1;

    // the whole front advances unless the compare stage must hold its last byte
    assign o_in_stall = hold;

    // decode position, load digest, issue store read
    pkcsck_front #(
        .MAX_DIGEST_BYTES(MAX_DIGEST_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .i_adv      (!hold),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_s1_valid (s1_valid),
        .o_s1       (s1)
    );

    // digest bytes, read in the cycle before the compare that uses them
    pkcsck_dstore #(
        .MAX_DIGEST_BYTES(MAX_DIGEST_BYTES)
    ) u_dstore (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // compare, accumulate mismatch, report per block
    pkcsck_verdict u_verdict (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .i_rd_data  (rd_data),
        .i_out_stall(i_out_stall),
        .o_hold     (hold),
        .o_out_valid(o_out_valid),
        .o_out_beat (o_out_beat)
    );

endmodule

[bench/tb.sv]
// Self-checking bench for pkcs1_v15_padding_checker_top: streams digest and block beats,
// predicts each verdict in a cycle-free model and compares it with the output channel.
// Depends on pkcsck_pkg and the checker RTL.
module tb;
    import pkcsck_pkg::*;

    localparam int STORE_DEPTH     = DEFAULT_MAX_DIGEST_BYTES;
    localparam int CYCLE_LIMIT     = 400000;
    // settle time after the last verdict is taken
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_BEATS    = 650;
    localparam int NO_FLIP         = -1;
    localparam int NUM_DIR         = 22;

    // DigestInfo prefixes, first byte in the top bits
    localparam logic [151:0] DI_SHA256 =
        152'h30_31_30_0D_06_09_60_86_48_01_65_03_04_02_01_05_00_04_20;
    localparam logic [151:0] DI_SHA384 =
        152'h30_41_30_0D_06_09_60_86_48_01_65_03_04_02_02_05_00_04_30;

    // idling phases: none, sender gaps, receiver stalls, both lightly
    localparam int GAP_PCT   [4] = '{0, 60, 0, 9};
    localparam int STALL_PCT [4] = '{0, 0, 60, 9};

    // One directed block: optional register writes, digest loads, then one block
    typedef struct packed {
        bit         cfg;       // write both registers first
        logic [9:0] bb;        // block_bytes
        logic [9:0] dkw;       // digest_kind write word, only bit 0 counts
        int         digests;   // digest beats ahead of the block
        int         flip_at;   // block position to corrupt, NO_FLIP for none
        bit         scramble;  // random block bytes
        int         noise;     // percent chance of a digest beat before each block beat
        bit         pinned;    // verdict below is typed in, not predicted
        t_out_beat  want;
    } t_dir_row;

    // For the 62-byte SHA-256 and 78-byte SHA-384 frames: separator at 10,
    // prefix at 11..29, digest from 30 on.
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        // reset registers; more digest beats than the store holds
        '{1'b0, 10'd256,  10'h000, 52, NO_FLIP, 1'b0, 0,  1'b1, '{1'b1, ST_OK}},
        // shortest frames that fit, and one byte less
        '{1'b1, 10'd62,   10'h000, 32, NO_FLIP, 1'b0, 0,  1'b1, '{1'b1, ST_OK}},
        '{1'b1, 10'd61,   10'h000, 0,  NO_FLIP, 1'b0, 0,  1'b1, '{1'b0, ST_TOO_SHORT}},
        '{1'b1, 10'd78,   10'h001, 48, NO_FLIP, 1'b0, 0,  1'b1, '{1'b1, ST_OK}},
        '{1'b1, 10'd77,   10'h3FF, 0,  NO_FLIP, 1'b0, 0,  1'b1, '{1'b0, ST_TOO_SHORT}},
        // longest block; lengths above the maximum clamp to it
        '{1'b1, 10'd1023, 10'h001, 50, NO_FLIP, 1'b0, 0,  1'b1, '{1'b1, ST_OK}},
        // zero length acts as one byte
        '{1'b1, 10'd0,    10'h000, 0,  NO_FLIP, 1'b0, 0,  1'b1, '{1'b0, ST_TOO_SHORT}},
        '{1'b1, 10'd1,    10'h001, 0,  NO_FLIP, 1'b0, 0,  1'b1, '{1'b0, ST_TOO_SHORT}},
        // one bad byte in each region of the frame
        '{1'b1, 10'd62,   10'h3FE, 32, 0,       1'b0, 0,  1'b1, '{1'b0, ST_MISMATCH}},
        '{1'b0, 10'd0,    10'h000, 0,  1,       1'b0, 0,  1'b1, '{1'b0, ST_MISMATCH}},
        '{1'b0, 10'd0,    10'h000, 0,  5,       1'b0, 0,  1'b1, '{1'b0, ST_MISMATCH}},
        '{1'b0, 10'd0,    10'h000, 0,  10,      1'b0, 0,  1'b1, '{1'b0, ST_MISMATCH}},
        '{1'b0, 10'd0,    10'h000, 0,  11,      1'b0, 0,  1'b1, '{1'b0, ST_MISMATCH}},
        '{1'b0, 10'd0,    10'h000, 0,  61,      1'b0, 0,  1'b1, '{1'b0, ST_MISMATCH}},
        '{1'b1, 10'd78,   10'h001, 48, 12,      1'b0, 0,  1'b1, '{1'b0, ST_MISMATCH}},
        '{1'b0, 10'd0,    10'h000, 0,  29,      1'b0, 0,  1'b1, '{1'b0, ST_MISMATCH}},
        // digest beats mixed into the block
        '{1'b0, 10'd0,    10'h000, 16, NO_FLIP, 1'b0, 30, 1'b0, '{1'b0, ST_OK}},
        // SHA-384 frame with padding to spare
        '{1'b1, 10'd90,   10'h001, 48, NO_FLIP, 1'b0, 0,  1'b1, '{1'b1, ST_OK}},
        // no digest beats: the store keeps the last digest
        '{1'b1, 10'd100,  10'h000, 0,  NO_FLIP, 1'b0, 0,  1'b1, '{1'b1, ST_OK}},
        '{1'b0, 10'd0,    10'h000, 0,  NO_FLIP, 1'b1, 0,  1'b0, '{1'b0, ST_OK}},
        // long enough for SHA-256 but not for SHA-384
        '{1'b1, 10'd62,   10'h155, 0,  NO_FLIP, 1'b0, 0,  1'b1, '{1'b0, ST_TOO_SHORT}},
        '{1'b1, 10'd127,  10'h000, 32, NO_FLIP, 1'b0, 10, 1'b0, '{1'b0, ST_OK}}
    };

    logic             i_clk     = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    t_cfg_reg         cfg_index = REG_BLOCK_BYTES;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in_beat         in_beat   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_beat        out_beat;

    pkcs1_v15_padding_checker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Verdict predictor: own copy of registers, digest store and counters
    // ------------------------------------------------------------------
    logic [9:0] cfg_block_bytes = BLOCK_BYTES_RESET;
    logic       cfg_sha384      = 1'b0;
    logic [7:0] digest_mem [STORE_DEPTH];
    int         load_idx        = 0;
    int         blk_pos         = 0;
    bit         bad_seen        = 1'b0;

    t_out_beat  verdict_q [$];
    bit         pin_on      = 1'b0;
    t_out_beat  pinned_beat = '0;
    int         stim_beats  = 0;
    int         errors      = 0;
    int         cycles      = 0;
    int         gap_pct     = 0;
    int         stall_pct   = 0;

    function automatic int frame_len();
        int n;
        n = int'(cfg_block_bytes);
        if (n == 0) n = 1;
        if (n > MAX_BLOCK_BYTES) n = MAX_BLOCK_BYTES;
        return n;
    endfunction

    function automatic int digest_len();
        return cfg_sha384 ? 48 : 32;
    endfunction

    function automatic bit frame_too_short();
        return frame_len() < int'(PREFIX_LEN) + digest_len() + int'(FRAME_OVERHEAD);
    endfunction

    // Byte the encoding holds at a position; only valid for a frame that fits
    function automatic logic [7:0] encoding_byte(int pos);
        int pad;
        int idx;
        pad = frame_len() - int'(PREFIX_LEN) - digest_len() - 3;
        if (pos == 0) return BYTE_ZERO;
        if (pos == 1) return BYTE_ONE;
        if (pos < 2 + pad) return BYTE_PAD;
        if (pos == 2 + pad) return BYTE_ZERO;
        if (pos < 3 + pad + int'(PREFIX_LEN)) begin
            idx = pos - 3 - pad;
            return cfg_sha384 ? DI_SHA384[(18 - idx) * 8 +: 8] : DI_SHA256[(18 - idx) * 8 +: 8];
        end
        idx = pos - 3 - pad - int'(PREFIX_LEN);
        if (idx >= STORE_DEPTH) return BYTE_ZERO;
        return digest_mem[idx];
    endfunction

    // Advance the model by one accepted beat; report the verdict it closes, if any
    function automatic void predict_verdict(input t_in_beat b, output bit got,
                                            output t_out_beat v);
        int len;
        bit short_frame;
        got = 1'b0;
        v   = '0;
        if (b.kind == KIND_DIGEST) begin
            if (load_idx < STORE_DEPTH) begin
                digest_mem[load_idx] = b.data_byte;
                load_idx++;
            end
            return;
        end
        len         = frame_len();
        short_frame = frame_too_short();
        if (!short_frame && blk_pos < len && encoding_byte(blk_pos) != b.data_byte)
            bad_seen = 1'b1;
        if (blk_pos + 1 >= len) begin
            got = 1'b1;
            if (short_frame) begin
                v.matched = 1'b0;
                v.status  = ST_TOO_SHORT;
            end else if (bad_seen) begin
                v.matched = 1'b0;
                v.status  = ST_MISMATCH;
            end else begin
                v.matched = 1'b1;
                v.status  = ST_OK;
            end
            blk_pos  = 0;
            bad_seen = 1'b0;
            load_idx = 0;
        end else begin
            blk_pos = (blk_pos + 1) & 10'h3FF;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one beat, hold it until taken, then log its verdict if it closes a block
    task automatic push_byte(input logic kind, input logic [7:0] data);
        t_in_beat  b;
        bit        got;
        t_out_beat v;
        b.kind      = kind;
        b.data_byte = data;
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        // digest beats past a full store do nothing; leave them out of the count
        if (kind == KIND_BLOCK || load_idx < STORE_DEPTH) stim_beats++;
        predict_verdict(b, got, v);
        if (got) begin
            verdict_q.push_back(pin_on ? pinned_beat : v);
        end
    endtask

    task automatic load_digest(input int n);
        repeat (n) push_byte(KIND_DIGEST, 8'($urandom_range(255)));
    endtask

    // Stream one full block, built byte by byte from the current model state
    task automatic run_block(input int flip_at, input bit scramble, input int noise);
        int         len;
        int         p;
        bit         short_frame;
        logic [7:0] v;
        len         = frame_len();
        short_frame = frame_too_short();
        for (p = 0; p < len; p++) begin
            while ($urandom_range(99) < noise) push_byte(KIND_DIGEST, 8'($urandom_range(255)));
            if (short_frame || scramble) v = 8'($urandom_range(255));
            else v = encoding_byte(blk_pos);
            if (p == flip_at) v = v ^ 8'($urandom_range(255, 1));
            push_byte(KIND_BLOCK, v);
        end
    endtask

    // Drop valid and wait until every verdict is in and the pipe is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write block_bytes, then digest_kind; only while the block is idle
    task automatic set_config(input logic [9:0] bb, input logic [9:0] dkw);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BLOCK_BYTES;
        cfg_wdata <= bb;
        @(posedge i_clk);
        cfg_index <= REG_DIGEST_KIND;
        cfg_wdata <= dkw;
        @(posedge i_clk);
        cfg_we          <= 1'b0;
        cfg_block_bytes  = bb;
        cfg_sha384       = dkw[0];
    endtask

    // Mostly well-formed frames near the minimum length; some too short, some at the
    // maximum, some corrupted, scrambled or with digest beats mixed in
    task automatic random_round();
        logic [9:0] dkw;
        logic [9:0] bb;
        int         lo;
        int         pick;
        int         flip;
        int         noise;
        bit         scramble;
        if ($urandom_range(99) < 50) begin
            dkw  = 10'($urandom_range(1023));
            lo   = int'(PREFIX_LEN) + (dkw[0] ? 48 : 32) + int'(FRAME_OVERHEAD);
            pick = $urandom_range(99);
            if (pick < 65) bb = 10'(lo + $urandom_range(24));
            else if (pick < 85) bb = 10'($urandom_range(lo - 1));
            else if (pick < 93) bb = 10'(MAX_BLOCK_BYTES);
            else bb = 10'($urandom_range(1023));
            settle();
            set_config(bb, dkw);
        end
        pick = $urandom_range(99);
        if (pick < 85) load_digest(digest_len());
        else if (pick < 95) load_digest($urandom_range(60));
        flip = NO_FLIP;
        if ($urandom_range(99) < 40) flip = $urandom_range(frame_len() - 1);
        scramble = ($urandom_range(99) < 5);
        noise    = ($urandom_range(99) < 15) ? 10 : 0;
        run_block(flip, scramble, noise);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, compare each taken beat with the oldest verdict
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : verdict_check
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                $error("verdict with none pending: matched %0d status %0d",
                       out_beat.matched, out_beat.status);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (out_beat.matched !== want.matched) begin
                    $error("matched: expected %0d, got %0d", want.matched, out_beat.matched);
                    errors++;
                end
                if (out_beat.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_beat.status);
                    errors++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: a hang ends the run as a failure
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[pkcs1_v15_padding_checker_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed rows, random rounds across idling phases, drain
    // ------------------------------------------------------------------
    initial begin
        int r;
        int round;
        int phase;
        int base_beats;

        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed rows; the first one loads the whole store so no empty entry is ever read
        gap_pct   = GAP_PCT[3];
        stall_pct = STALL_PCT[3];
        for (r = 0; r < NUM_DIR; r++) begin
            if (DIR_ROWS[r].cfg) begin
                settle();
                set_config(DIR_ROWS[r].bb, DIR_ROWS[r].dkw);
            end
            pin_on      = DIR_ROWS[r].pinned;
            pinned_beat = DIR_ROWS[r].want;
            load_digest(DIR_ROWS[r].digests);
            run_block(DIR_ROWS[r].flip_at, DIR_ROWS[r].scramble, DIR_ROWS[r].noise);
            pin_on = 1'b0;
        end

        // Random rounds; rotate the idling phase every block
        base_beats    = stim_beats;
        round         = 0;
        while (stim_beats - base_beats < RANDOM_BEATS) begin
            phase     = round % 4;
            gap_pct   = GAP_PCT[phase];
            stall_pct = STALL_PCT[phase];
            random_round();
            round++;
        end

        // Drain: every verdict in, then more quiet cycles to catch stray output
        settle();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("[pkcs1_v15_padding_checker_top] OK");
        end else begin
            $display("[pkcs1_v15_padding_checker_top] ERROR");
        end
        $finish;
    end

endmodule
